FILE: rtl/ptpc_pkg.sv
// ----------------------------------------------------------------------------
// ptpc_pkg: shared types and constants of the point-to-pixel colorizer
// Holds the item codes, register indexes, pipeline payload types and the
// saturating adder that the transform stages use.
// ----------------------------------------------------------------------------
package ptpc_pkg;

   // Item codes.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_POINT = 1'b1;

   // Register indexes of the configuration port.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_COLS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_ROWS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROW0_FIRST = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROW0_SECOND = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROW1_FIRST = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ROW1_SECOND = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ROW2_FIRST = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ROW2_SECOND = 3'd7;

   // Register reset values.
   localparam logic [9:0] FRAME_SIZE_RESET = 10'd512;
   localparam logic [63:0] ROW0_FIRST_RESET = 64'h0000_0000_0001_0000;
   localparam logic [63:0] ROW1_FIRST_RESET = 64'h0001_0000_0000_0000;
   localparam logic [63:0] ROW2_SECOND_RESET = 64'h0000_0000_0001_0000;

   // Field widths.
   localparam int SIZE_W = 10;
   localparam int POS_W = 9;
   localparam int COORD_W = 32;
   localparam int ACC_W = 64;
   // The quotient must stay below a frame size, so it never needs more bits.
   localparam int QUO_W = SIZE_W;
   localparam int DIV_STAGES = QUO_W + 2;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // Transform: twelve Q16.16 entries, entry r*4+c is row r column c.
   typedef logic [11:0][COORD_W-1:0] mat_type;

   // Fields of a pixel-write item that ride along with every item.
   typedef struct packed {
      logic operation;
      logic [POS_W-1:0] write_col;
      logic [POS_W-1:0] write_row;
      logic [23:0] rgb;
   } side_type;

   // Result of the transform: the two numerators and the depth.
   typedef struct packed {
      logic [ACC_W-1:0] num_x;
      logic [ACC_W-1:0] num_y;
      logic [ACC_W-1:0] den;
      side_type side;
   } proj_type;

   // One quotient lane of the divider.
   typedef struct packed {
      logic [ACC_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic neg;
      logic ovf;
   } lane_type;

   // Payload of one divider stage.
   typedef struct packed {
      lane_type lx;
      lane_type ly;
      logic [ACC_W-1:0] den;
      logic zero;
      side_type side;
   } div_type;

   // Signed add that clamps to the 64-bit range.
   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
      logic [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end
      return s[ACC_W-1:0];
   endfunction

   // One restoring division step for quotient bit sh.
   function automatic lane_type div_step(input lane_type l, input logic [ACC_W-1:0] d,
                                         input int sh);
      logic [ACC_W+QUO_W-1:0] dsh;
      lane_type r;
      dsh = {{QUO_W{1'b0}}, d} << sh;
      r = l;
      if ({{QUO_W{1'b0}}, l.rem} >= dsh) begin
         r.rem = l.rem - dsh[ACC_W-1:0];
         r.quo[sh] = 1'b1;
      end
      return r;
   endfunction

endpackage

FILE: rtl/ptpc_if.sv
// ----------------------------------------------------------------------------
// ptpc_if: channel interfaces of the point-to-pixel colorizer
// Request, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface ptpc_req_if;
   import ptpc_pkg::*;
   logic valid;
   logic ready;
   logic operation;
   logic [8:0] write_col;
   logic [8:0] write_row;
   logic [7:0] write_red;
   logic [7:0] write_green;
   logic [7:0] write_blue;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   modport source(output valid, operation, write_col, write_row, write_red, write_green,
                  write_blue, point_x, point_y, point_z, input ready);
   modport sink(input valid, operation, write_col, write_row, write_red, write_green,
                write_blue, point_x, point_y, point_z, output ready);
endinterface

interface ptpc_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic [7:0] color_red;
   logic [7:0] color_green;
   logic [7:0] color_blue;
   logic [7:0] color_alpha;
   logic [8:0] image_col;
   logic [8:0] image_row;
   modport source(output valid, hit, color_red, color_green, color_blue, color_alpha,
                  image_col, image_row, input ready);
   modport sink(input valid, hit, color_red, color_green, color_blue, color_alpha,
                image_col, image_row, output ready);
endinterface

interface ptpc_csr_if;
   logic valid;
   logic ready;
   logic [2:0] index;
   logic [63:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/ptpc_transform.sv
// ----------------------------------------------------------------------------
// ptpc_transform: four-stage matrix-vector pipeline
// Multiplies the point by the top three transform rows, then sums the terms
// with saturation, one addition in each stage after the product stage.
// ----------------------------------------------------------------------------
module ptpc_transform (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic signed [31:0] point_x,
   input  logic signed [31:0] point_y,
   input  logic signed [31:0] point_z,
   input  ptpc_pkg::side_type in_side,
   input  ptpc_pkg::mat_type mat,
   output logic out_valid,
   input  logic out_ready,
   output ptpc_pkg::proj_type out_proj
);
   import ptpc_pkg::*;

   localparam int NST = 4;

   logic v_ff [NST];
   logic en [NST];
   side_type side_ff [NST];
   logic signed [ACC_W-1:0] px_ff [3];
   logic signed [ACC_W-1:0] py_ff [3];
   logic signed [ACC_W-1:0] pz_ff [3];
   logic signed [ACC_W-1:0] pt_ff [3];
   logic signed [ACC_W-1:0] a2_ff [3];
   logic signed [ACC_W-1:0] z2_ff [3];
   logic signed [ACC_W-1:0] t2_ff [3];
   logic signed [ACC_W-1:0] a3_ff [3];
   logic signed [ACC_W-1:0] t3_ff [3];
   logic signed [ACC_W-1:0] a4_ff [3];

   // A stage takes new data when it is empty or its successor moves on.
   always_comb begin
      en[NST-1] = !v_ff[NST-1] || out_ready;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end
   assign in_ready = en[0];

   // Valid bits follow the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NST; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Products, then one saturating addition per stage.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         side_ff[0] <= in_side;
         for (int r = 0; r < 3; r++) begin
            px_ff[r] <= $signed(mat[r*4]) * point_x;
            py_ff[r] <= $signed(mat[r*4+1]) * point_y;
            pz_ff[r] <= $signed(mat[r*4+2]) * point_z;
            pt_ff[r] <= {{16{mat[r*4+3][COORD_W-1]}}, mat[r*4+3], 16'h0000};
         end
      end
      if (en[1]) begin
         side_ff[1] <= side_ff[0];
         for (int r = 0; r < 3; r++) begin
            a2_ff[r] <= sat_add(px_ff[r], py_ff[r]);
            z2_ff[r] <= pz_ff[r];
            t2_ff[r] <= pt_ff[r];
         end
      end
      if (en[2]) begin
         side_ff[2] <= side_ff[1];
         for (int r = 0; r < 3; r++) begin
            a3_ff[r] <= sat_add(a2_ff[r], z2_ff[r]);
            t3_ff[r] <= t2_ff[r];
         end
      end
      if (en[3]) begin
         side_ff[3] <= side_ff[2];
         for (int r = 0; r < 3; r++) begin
            a4_ff[r] <= sat_add(a3_ff[r], t3_ff[r]);
         end
      end
   end

   assign out_valid = v_ff[NST-1];
   assign out_proj.num_x = a4_ff[0];
   assign out_proj.num_y = a4_ff[1];
   assign out_proj.den = a4_ff[2];
   assign out_proj.side = side_ff[NST-1];

endmodule

FILE: rtl/ptpc_divider.sv
// ----------------------------------------------------------------------------
// ptpc_divider: pipelined restoring divider, two lanes
// Divides both numerators by the depth, one quotient bit per stage, after
// a sign stage and a quotient overflow stage.
// ----------------------------------------------------------------------------
module ptpc_divider (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  ptpc_pkg::proj_type in_proj,
   output logic out_valid,
   input  logic out_ready,
   output ptpc_pkg::div_type out_div
);
   import ptpc_pkg::*;

   logic v_ff [DIV_STAGES];
   logic en [DIV_STAGES];
   div_type st_ff [DIV_STAGES];
   div_type st_in [DIV_STAGES];
   div_type prep;

   // Stage enables from the output back.
   always_comb begin
      en[DIV_STAGES-1] = !v_ff[DIV_STAGES-1] || out_ready;
      for (int k = DIV_STAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < DIV_STAGES; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Signs, magnitudes and the zero-depth flag.
   always_comb begin
      prep = '0;
      prep.side = in_proj.side;
      prep.zero = (in_proj.den == '0);
      prep.den = in_proj.den[ACC_W-1] ? (~in_proj.den + 1'b1) : in_proj.den;
      prep.lx.rem = in_proj.num_x[ACC_W-1] ? (~in_proj.num_x + 1'b1) : in_proj.num_x;
      prep.ly.rem = in_proj.num_y[ACC_W-1] ? (~in_proj.num_y + 1'b1) : in_proj.num_y;
      prep.lx.neg = in_proj.num_x[ACC_W-1] ^ in_proj.den[ACC_W-1];
      prep.ly.neg = in_proj.num_y[ACC_W-1] ^ in_proj.den[ACC_W-1];
   end

   // Next value of every stage. A quotient that does not fit the quotient
   // width lies outside any frame; after that test comes one quotient bit
   // per stage, most significant first.
   always_comb begin
      st_in[0] = prep;
      st_in[1] = st_ff[0];
      st_in[1].lx.ovf = {{QUO_W{1'b0}}, st_ff[0].lx.rem} >= {st_ff[0].den, {QUO_W{1'b0}}};
      st_in[1].ly.ovf = {{QUO_W{1'b0}}, st_ff[0].ly.rem} >= {st_ff[0].den, {QUO_W{1'b0}}};
      for (int k = 2; k < DIV_STAGES; k++) begin
         st_in[k] = st_ff[k-1];
         st_in[k].lx = div_step(st_ff[k-1].lx, st_ff[k-1].den, DIV_STAGES - 1 - k);
         st_in[k].ly = div_step(st_ff[k-1].ly, st_ff[k-1].den, DIV_STAGES - 1 - k);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (en[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_div = st_ff[DIV_STAGES-1];

endmodule

FILE: rtl/point_to_pixel_colorizer.sv
// ----------------------------------------------------------------------------
// point_to_pixel_colorizer: projects 3-D points into a stored RGB frame
// Channel | Modport | Moves
// req     | sink    | pixel-write or point item
// rsp     | source  | colorized result item, one per point item
// csr     | sink    | register write, index and 64-bit data
// One item enters per cycle unless rsp stalls; a point passes four transform
// stages, twelve divider stages and the frame memory stage to its result.
// The frame memory takes one write or one read per cycle at that last stage.
// Reset clears the registers to their defaults and empties the pipeline;
// the frame contents are undefined until written.
// A stall at rsp holds only the stages that are full behind it.
// ----------------------------------------------------------------------------
module point_to_pixel_colorizer #(
   parameter int MAX_COLS = 512,
   parameter int MAX_ROWS = 512
) (
   input  logic clock,
   input  logic reset,
   ptpc_req_if.sink req,
   ptpc_rsp_if.source rsp,
   ptpc_csr_if.sink csr
);
   import ptpc_pkg::*;

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [SIZE_W-1:0] frame_cols_ff;
   logic [SIZE_W-1:0] frame_rows_ff;
   logic [ACC_W-1:0] pair_ff [6];
   mat_type mat;
   side_type req_side;
   logic t_valid, t_ready;
   proj_type t_proj;
   logic d_valid, d_ready;
   div_type d_div;
   logic hit_x, hit_y, hit_in, wr_ok;
   logic [AW-1:0] raddr, waddr;
   logic rsp_v_ff, hit_ff;
   logic [QUO_W-1:0] col_ff, row_ff;
   logic [23:0] pix_ff;
   logic [23:0] frame_mem [DEPTH];

   // Configuration registers.
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_cols_ff <= FRAME_SIZE_RESET;
         frame_rows_ff <= FRAME_SIZE_RESET;
         pair_ff[0] <= ROW0_FIRST_RESET;
         pair_ff[1] <= '0;
         pair_ff[2] <= ROW1_FIRST_RESET;
         pair_ff[3] <= '0;
         pair_ff[4] <= '0;
         pair_ff[5] <= ROW2_SECOND_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            REG_FRAME_COLS: frame_cols_ff <= csr.data[SIZE_W-1:0];
            REG_FRAME_ROWS: frame_rows_ff <= csr.data[SIZE_W-1:0];
            REG_ROW0_FIRST: pair_ff[0] <= csr.data;
            REG_ROW0_SECOND: pair_ff[1] <= csr.data;
            REG_ROW1_FIRST: pair_ff[2] <= csr.data;
            REG_ROW1_SECOND: pair_ff[3] <= csr.data;
            REG_ROW2_FIRST: pair_ff[4] <= csr.data;
            REG_ROW2_SECOND: pair_ff[5] <= csr.data;
            default: ;
         endcase
      end
   end

   // Unpack the register pairs into the twelve transform entries.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         mat[r*4] = pair_ff[2*r][31:0];
         mat[r*4+1] = pair_ff[2*r][63:32];
         mat[r*4+2] = pair_ff[2*r+1][31:0];
         mat[r*4+3] = pair_ff[2*r+1][63:32];
      end
   end

   assign req_side.operation = req.operation;
   assign req_side.write_col = req.write_col;
   assign req_side.write_row = req.write_row;
   assign req_side.rgb = {req.write_red, req.write_green, req.write_blue};

   ptpc_transform u_transform (
      .clock(clock),
      .reset(reset),
      .in_valid(req.valid),
      .in_ready(req.ready),
      .point_x(req.point_x),
      .point_y(req.point_y),
      .point_z(req.point_z),
      .in_side(req_side),
      .mat(mat),
      .out_valid(t_valid),
      .out_ready(t_ready),
      .out_proj(t_proj)
   );

   ptpc_divider u_divider (
      .clock(clock),
      .reset(reset),
      .in_valid(t_valid),
      .in_ready(t_ready),
      .in_proj(t_proj),
      .out_valid(d_valid),
      .out_ready(d_ready),
      .out_div(d_div)
   );

   // Range tests on the quotients: a negative quotient only passes as zero.
   always_comb begin
      hit_x = !d_div.zero && !d_div.lx.ovf && (!d_div.lx.neg || d_div.lx.quo == '0)
              && (d_div.lx.quo < frame_cols_ff) && (int'(d_div.lx.quo) < MAX_COLS);
      hit_y = !d_div.zero && !d_div.ly.ovf && (!d_div.ly.neg || d_div.ly.quo == '0)
              && (d_div.ly.quo < frame_rows_ff) && (int'(d_div.ly.quo) < MAX_ROWS);
      hit_in = hit_x && hit_y;
      raddr = hit_in ? AW'(int'(d_div.ly.quo) * MAX_COLS + int'(d_div.lx.quo)) : '0;
      wr_ok = (int'(d_div.side.write_col) < MAX_COLS) && (int'(d_div.side.write_row) < MAX_ROWS);
      waddr = wr_ok ? AW'(int'(d_div.side.write_row) * MAX_COLS + int'(d_div.side.write_col))
                    : '0;
   end

   // Output stage; write items leave the pipeline here.
   assign d_ready = !rsp_v_ff || rsp.ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (d_ready) begin
         rsp_v_ff <= d_valid && (d_div.side.operation == OP_POINT);
      end
   end

   always_ff @(posedge clock) begin
      if (d_ready) begin
         hit_ff <= hit_in;
         col_ff <= hit_in ? d_div.lx.quo : '0;
         row_ff <= hit_in ? d_div.ly.quo : '0;
      end
   end

   // Frame memory: one write or one registered read per cycle, in item order.
   always_ff @(posedge clock) begin
      if (d_ready && d_valid) begin
         if (d_div.side.operation == OP_WRITE) begin
            if (wr_ok) begin
               frame_mem[waddr] <= d_div.side.rgb;
            end
         end else begin
            pix_ff <= frame_mem[raddr];
         end
      end
   end

   assign rsp.valid = rsp_v_ff;
   assign rsp.hit = hit_ff;
   assign rsp.color_red = hit_ff ? pix_ff[23:16] : 8'h00;
   assign rsp.color_green = hit_ff ? pix_ff[15:8] : 8'h00;
   assign rsp.color_blue = hit_ff ? pix_ff[7:0] : 8'h00;
   assign rsp.color_alpha = hit_ff ? ALPHA_OPAQUE : 8'h00;
   assign rsp.image_col = col_ff[POS_W-1:0];
   assign rsp.image_row = row_ff[POS_W-1:0];

`ifndef SYNTHESIS
   // A hit always lies inside the configured frame.
   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && hit_ff |-> (col_ff < frame_cols_ff) && (int'(col_ff) < MAX_COLS))
      else $error("hit column outside the frame");
   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && hit_ff |-> (row_ff < frame_rows_ff) && (int'(row_ff) < MAX_ROWS))
      else $error("hit row outside the frame");
   // A pixel-write item never turns into a result.
   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      d_valid && d_ready && (d_div.side.operation == OP_WRITE) |=> !rsp_v_ff)
      else $error("write item produced a result");
`endif

endmodule
